// ===== design/round_robin_quantum_scheduler_defines.svh =====
// assertion macros for the round-robin quantum scheduler
`ifndef ROUND_ROBIN_QUANTUM_SCHEDULER_DEFINES_SVH
`define ROUND_ROBIN_QUANTUM_SCHEDULER_DEFINES_SVH

`ifndef ASSERT_OFF
`define RRQS_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define RRQS_ASSERT_NEVER(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define RRQS_ASSERT(label, clk, rst, prop, msg)
`define RRQS_ASSERT_NEVER(label, clk, rst, cond, msg)
`endif

`endif

// ===== design/rrqs_pkg.sv =====
// shared types and constants for the round-robin quantum scheduler
`default_nettype none

package rrqs_pkg;

  localparam int SLOT_W  = 2;
  localparam int TIME_W  = 8;
  localparam int CLOCK_W = 16;

  localparam logic [TIME_W-1:0]  QUANTUM_RESET = 8'd4;
  localparam logic [TIME_W-1:0]  QUANTUM_MIN   = 8'd1;
  localparam logic [CLOCK_W-1:0] CLOCK_MAX     = 16'hFFFF;

  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_STEP = 1'b1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CALC,
    S_EMIT
  } rrqs_state_t;

endpackage

`default_nettype wire

// ===== design/rrqs_ram.sv =====
// generic simple dual-port ram with registered read
`default_nettype none

module rrqs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== design/round_robin_quantum_scheduler.sv =====
// Round-robin scheduler with a fixed time quantum over NUM_SLOTS job slots.
// A load transaction (mode 0) writes a burst time into a slot and gives no
// result; a slot index at or beyond NUM_SLOTS is ignored. A step transaction
// (mode 1) picks the first pending slot at or after the rotating pointer,
// serves it for min(quantum, remaining) and returns one result; with nothing
// pending it returns all_done with a zero slice. Remaining times live in a ram
// with a registered read, so a step is a read-modify-write: the entry is read
// at acceptance, updated and written back in the next cycle, and the result
// is held in the same cycle (at acceptance when nothing is pending, as the
// update is skipped). A new transaction is taken once a step has left S_EMIT
// for S_IDLE, and a load does not stall the input; a step waits in S_EMIT with
// the input stalled while the previous result still sits stalled at the
// output. A pending flag per slot, cleared at reset, marks the nonzero
// entries, so the ram needs no clearing pass. The global clock saturates at
// 65535 and a quantum of zero acts as one.
`default_nettype none
`include "round_robin_quantum_scheduler_defines.svh"

module round_robin_quantum_scheduler #(
  parameter int NUM_SLOTS = 4
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  // configuration
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [rrqs_pkg::TIME_W-1:0]   quantum,
  // input channel
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic                          mode,
  input  wire logic [rrqs_pkg::SLOT_W-1:0]   slot_index,
  input  wire logic [rrqs_pkg::TIME_W-1:0]   burst_time,
  // output channel
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic      [rrqs_pkg::SLOT_W-1:0]   served_slot,
  output logic      [rrqs_pkg::TIME_W-1:0]   slice_length,
  output logic      [rrqs_pkg::TIME_W-1:0]   remaining_after,
  output logic      [rrqs_pkg::CLOCK_W-1:0]  clock_after,
  output logic                               job_finished,
  output logic                               all_done
);

  import rrqs_pkg::*;

  localparam int IDX_W = $clog2(NUM_SLOTS);

  rrqs_state_t state, state_next;

  logic [TIME_W-1:0]    quantum_reg;
  logic [NUM_SLOTS-1:0] nz;
  logic [IDX_W-1:0]     ptr;
  logic [IDX_W-1:0]     sel_idx;
  logic [CLOCK_W-1:0]   gclk;

  // result waiting for the output register
  logic [SLOT_W-1:0]  res_slot;
  logic [TIME_W-1:0]  res_slice;
  logic [TIME_W-1:0]  res_rem;
  logic [CLOCK_W-1:0] res_clock;
  logic               res_finished;
  logic               res_all_done;

  logic in_accept;
  logic is_load;
  logic is_step;
  logic load_ok;
  logic [IDX_W-1:0] load_addr;
  logic [IDX_W+SLOT_W-1:0] load_wide;
  logic [IDX_W+SLOT_W-1:0] sel_wide;

  logic             hi_found, lo_found, any_pending;
  logic [IDX_W-1:0] hi_idx, lo_idx, find_idx;

  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  logic [TIME_W-1:0] ram_wdata;
  logic [TIME_W-1:0] ram_rdata;

  logic [TIME_W-1:0]    q_eff, slice, rem_new;
  logic [CLOCK_W:0]     clk_sum;
  logic [CLOCK_W-1:0]   clk_new;
  logic [NUM_SLOTS-1:0] nz_after;
  logic [IDX_W-1:0]     ptr_after;
  logic                 out_free;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != S_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign is_load   = in_accept && (mode == MODE_LOAD);
  assign is_step   = in_accept && (mode == MODE_STEP);
  assign out_free  = !out_valid || !out_stall;

  assign load_wide = {{IDX_W{1'b0}}, slot_index};
  assign load_addr = load_wide[IDX_W-1:0];
  assign load_ok   = (32'(slot_index) < NUM_SLOTS);
  assign sel_wide  = {{SLOT_W{1'b0}}, sel_idx};

  // rotating priority search over the pending flags
  always_comb begin
    hi_found = 1'b0;
    lo_found = 1'b0;
    hi_idx   = '0;
    lo_idx   = '0;
    for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
      if (nz[i]) begin
        lo_found = 1'b1;
        lo_idx   = IDX_W'(i);
        if (IDX_W'(i) >= ptr) begin
          hi_found = 1'b1;
          hi_idx   = IDX_W'(i);
        end
      end
    end
    any_pending = lo_found;
    find_idx    = hi_found ? hi_idx : lo_idx;
  end

  // slice arithmetic on the entry read back from the ram
  always_comb begin
    q_eff   = (quantum_reg == '0) ? QUANTUM_MIN : quantum_reg;
    slice   = (ram_rdata < q_eff) ? ram_rdata : q_eff;
    rem_new = ram_rdata - slice;
    clk_sum = {1'b0, gclk} + {{(CLOCK_W + 1 - TIME_W){1'b0}}, slice};
    clk_new = clk_sum[CLOCK_W] ? CLOCK_MAX : clk_sum[CLOCK_W-1:0];
    nz_after          = nz;
    nz_after[sel_idx] = (rem_new != '0);
    ptr_after = (32'(sel_idx) == NUM_SLOTS - 1) ? '0 : sel_idx + 1'b1;
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = load_addr;
    ram_wdata = burst_time;
    if (state == S_CALC) begin
      ram_we    = 1'b1;
      ram_waddr = sel_idx;
      ram_wdata = rem_new;
    end else if (is_load && load_ok) begin
      ram_we = 1'b1;
    end
  end

  rrqs_ram #(
    .WIDTH(TIME_W),
    .DEPTH(NUM_SLOTS)
  ) u_table (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(find_idx),
    .rdata(ram_rdata)
  );

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (is_step) begin
          state_next = any_pending ? S_CALC : S_EMIT;
        end
      end
      S_CALC: state_next = S_EMIT;
      S_EMIT: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      quantum_reg <= QUANTUM_RESET;
    end else if (cfg_valid && cfg_ready) begin
      quantum_reg <= quantum;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      nz   <= '0;
      ptr  <= '0;
      gclk <= '0;
    end else if (state == S_CALC) begin
      nz   <= nz_after;
      ptr  <= ptr_after;
      gclk <= clk_new;
    end else if (is_load && load_ok) begin
      nz[load_addr] <= (burst_time != '0);
    end
  end

  always_ff @(posedge clk) begin
    if (is_step) begin
      sel_idx <= find_idx;
      if (!any_pending) begin
        res_slot     <= '0;
        res_slice    <= '0;
        res_rem      <= '0;
        res_clock    <= gclk;
        res_finished <= 1'b0;
        res_all_done <= 1'b1;
      end
    end else if (state == S_CALC) begin
      res_slot     <= sel_wide[SLOT_W-1:0];
      res_slice    <= slice;
      res_rem      <= rem_new;
      res_clock    <= clk_new;
      res_finished <= (rem_new == '0);
      res_all_done <= (nz_after == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_EMIT && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_EMIT && out_free) begin
      served_slot     <= res_slot;
      slice_length    <= res_slice;
      remaining_after <= res_rem;
      clock_after     <= res_clock;
      job_finished    <= res_finished;
      all_done        <= res_all_done;
    end
  end

  // pending flags only move on a load or on the write-back cycle
  `RRQS_ASSERT(a_flags_stable, clk, rst, (state == S_EMIT) |=> $stable(nz), "pending flags moved")
  // the slot chosen for a slice must still be pending when its entry comes back
  `RRQS_ASSERT(a_sel_pending, clk, rst, (state == S_CALC) |-> nz[sel_idx], "slot not pending")
  // the global clock only moves forward
  `RRQS_ASSERT(a_clock_mono, clk, rst, !rst |=> (gclk >= $past(gclk)), "clock went backwards")
  // a finished job leaves no time behind
  `RRQS_ASSERT_NEVER(a_finish_rem, clk, rst, out_valid && job_finished && |remaining_after, "time left")

endmodule

`default_nettype wire
